[hdl/bblr_pkg.sv]
// Shared constants and helpers for the Bayer-to-luma rotate block.
`timescale 1ns / 1ps
`default_nettype none
package bblr_pkg;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_DIM    = 4;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;
    localparam int ADDR_W     = 23;

    localparam logic [7:0] K_R   = 8'd76;
    localparam logic [7:0] K_G   = 8'd149;
    localparam logic [7:0] K_B   = 8'd29;
    localparam logic [7:0] K_RND = 8'd128;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ROTATE = 2'd2;

    // truncated mean of up to four 8-bit samples; /3 by reciprocal 683/2048
    function automatic logic [7:0] avg(input logic [9:0] sum, input logic [2:0] cnt);
        logic [19:0] prod;
        logic [7:0]  res;
        prod = {10'd0, sum} * 20'd683;
        unique case (cnt)
            3'd1:    res = sum[7:0];
            3'd2:    res = sum[8:1];
            3'd3:    res = prod[18:11];
            3'd4:    res = sum[9:2];
            default: res = 8'd0;
        endcase
        return res;
    endfunction
endpackage
`default_nettype wire

[hdl/bayer_bggr_to_luma_rotate.sv]
// Top level: BGGR demosaic to luma with rotated output addressing.
`timescale 1ns / 1ps
`default_nettype none
// Raw BGGR samples enter in raster order, one item per cycle unless the output stalls or
// an item with several results holds in_ready low. Each item costs one read and one write
// of a single 2048 x 16 line store (both rows above, one entry per column), then shifts a
// 3x3 window. Each item yields zero to four luma results (four only at the last pixel of
// the frame); the output stage issues one result per cycle while out_ready allows. A write
// to the width, height or rotate register restarts the frame at row 0, column 0. Line
// store contents are undefined after reset and need no clearing.
module bayer_bggr_to_luma_rotate
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  raw_pixel,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       luma,
    output logic [22:0]      out_address,
    output logic             last_of_run,
    output logic             frame_done
);
    localparam int CW = bblr_pkg::COL_W;
    localparam int RW = bblr_pkg::ROW_W;

    logic [bblr_pkg::FW_W-1:0] eff_w_reg;
    logic [bblr_pkg::FH_W-1:0] eff_h_reg;
    logic                      cw_reg;
    logic [CW-1:0]             col_reg;
    logic [RW-1:0]             row_reg;

    logic [15:0] mem [0:bblr_pkg::MAX_WIDTH-1];
    logic [15:0] rd_reg;

    logic          s1_valid_reg;
    logic [7:0]    s1_pix_reg;
    logic [CW-1:0] s1_c_reg;
    logic [RW-1:0] s1_r_reg;

    logic [7:0]    win_reg [0:8];
    logic [3:0]    mask_reg;
    logic [CW-1:0] b_c_reg;
    logic [RW-1:0] b_r_reg;

    logic          p1_valid_reg;
    logic [7:0]    p1_r_reg, p1_g_reg, p1_b_reg;
    logic [23:0]   p1_prod_reg;
    logic [RW-1:0] p1_add_reg;
    logic          p1_last_reg, p1_done_reg;

    logic          out_valid_reg;
    logic [7:0]    luma_reg;
    logic [22:0]   addr_reg;
    logic          last_reg, done_reg;

    logic adv, in_acc, xfer, single;
    logic [bblr_pkg::FW_W-1:0] wm1;
    logic [bblr_pkg::FH_W-1:0] hm1;
    logic [3:0] new_mask, pick_bit;
    logic [1:0] sel;
    logic [RW-1:0] py;
    logic [CW-1:0] px;
    logic [1:0] wy, wx;
    logic vu, vd, vl, vr;
    logic [7:0] n_c, n_u, n_d, n_l, n_r, n_ul, n_ur, n_dl, n_dr;
    logic [9:0] s_cross, s_diag, s_hor, s_ver;
    logic [2:0] c_cross, c_diag, c_hor, c_ver;
    logic [7:0] a_cross, a_diag, a_hor, a_ver;
    logic [7:0] cr, cg, cb;
    logic [CW-1:0] mx;
    logic [RW-1:0] addend;
    logic [15:0] luma_sum;
    logic [24:0] addr_sum;
    logic [bblr_pkg::FW_W-1:0] w_clamp;
    logic [bblr_pkg::FH_W-1:0] h_clamp;

    function automatic logic [3:0] widx(input logic [1:0] y, input logic [1:0] x);
        return {2'b00, y} * 4'd3 + {2'b00, x};
    endfunction

    assign wm1 = eff_w_reg - 1'b1;
    assign hm1 = eff_h_reg - 1'b1;
    assign adv = !out_valid_reg || out_ready;
    assign single = (mask_reg & (mask_reg - 4'd1)) == 4'd0;
    assign xfer = s1_valid_reg && adv && single;
    assign in_ready = !s1_valid_reg || xfer;
    assign in_acc = in_valid && in_ready;

    always_comb
    begin
        w_clamp = cfg_data[11:0];
        if (cfg_data[11:0] < 12'(bblr_pkg::MIN_DIM))
            w_clamp = 12'(bblr_pkg::MIN_DIM);
        else if (cfg_data[11:0] > 12'(bblr_pkg::MAX_WIDTH))
            w_clamp = 12'(bblr_pkg::MAX_WIDTH);
        h_clamp = cfg_data;
        if (cfg_data < 13'(bblr_pkg::MIN_DIM))
            h_clamp = 13'(bblr_pkg::MIN_DIM);
        else if (cfg_data > 13'(bblr_pkg::MAX_HEIGHT))
            h_clamp = 13'(bblr_pkg::MAX_HEIGHT);
    end

    always_comb
    begin
        new_mask[0] = (s1_r_reg != '0) && (s1_c_reg != '0);
        new_mask[1] = (s1_r_reg != '0) && ({1'b0, s1_c_reg} == wm1);
        new_mask[2] = ({1'b0, s1_r_reg} == hm1) && (s1_c_reg != '0);
        new_mask[3] = ({1'b0, s1_r_reg} == hm1) && ({1'b0, s1_c_reg} == wm1);
    end

    // pick the earliest pending result of the current item
    always_comb
    begin
        priority if (mask_reg[0])
            sel = 2'd0;
        else if (mask_reg[1])
            sel = 2'd1;
        else if (mask_reg[2])
            sel = 2'd2;
        else
            sel = 2'd3;
        pick_bit = 4'd1 << sel;
        py = b_r_reg - RW'(!sel[1]);
        px = b_c_reg - CW'(!sel[0]);
        wy = sel[1] ? 2'd2 : 2'd1;
        wx = sel[0] ? 2'd2 : 2'd1;
        vu = py != '0;
        vd = !sel[1] && ({1'b0, py} != hm1);
        vl = px != '0;
        vr = !sel[0] && ({1'b0, px} != wm1);
        n_c  = win_reg[widx(wy, wx)];
        n_u  = win_reg[widx(wy - 2'd1, wx)];
        n_d  = win_reg[widx(2'd2, wx)];
        n_l  = win_reg[widx(wy, wx - 2'd1)];
        n_r  = win_reg[widx(wy, 2'd2)];
        n_ul = win_reg[widx(wy - 2'd1, wx - 2'd1)];
        n_ur = win_reg[widx(wy - 2'd1, 2'd2)];
        n_dl = win_reg[widx(2'd2, wx - 2'd1)];
        n_dr = win_reg[widx(2'd2, 2'd2)];
        s_hor = (vl ? {2'b00, n_l} : 10'd0) + (vr ? {2'b00, n_r} : 10'd0);
        s_ver = (vu ? {2'b00, n_u} : 10'd0) + (vd ? {2'b00, n_d} : 10'd0);
        s_cross = s_hor + s_ver;
        s_diag = (vu && vl ? {2'b00, n_ul} : 10'd0) + (vu && vr ? {2'b00, n_ur} : 10'd0)
               + (vd && vl ? {2'b00, n_dl} : 10'd0) + (vd && vr ? {2'b00, n_dr} : 10'd0);
        c_hor = {2'b00, vl} + {2'b00, vr};
        c_ver = {2'b00, vu} + {2'b00, vd};
        c_cross = c_hor + c_ver;
        c_diag = {2'b00, vu && vl} + {2'b00, vu && vr} + {2'b00, vd && vl} + {2'b00, vd && vr};
        a_hor = bblr_pkg::avg(s_hor, c_hor);
        a_ver = bblr_pkg::avg(s_ver, c_ver);
        a_cross = bblr_pkg::avg(s_cross, c_cross);
        a_diag = bblr_pkg::avg(s_diag, c_diag);
        unique case ({py[0], px[0]})
            2'b00:
            begin
                cb = n_c; cg = a_cross; cr = a_diag;
            end
            2'b01:
            begin
                cg = n_c; cb = a_hor; cr = a_ver;
            end
            2'b10:
            begin
                cg = n_c; cr = a_hor; cb = a_ver;
            end
            default:
            begin
                cr = n_c; cg = a_cross; cb = a_diag;
            end
        endcase
        mx = cw_reg ? px : CW'(wm1 - {1'b0, px});
        addend = cw_reg ? RW'(hm1 - {1'b0, py}) : py;
    end

    assign luma_sum = {8'd0, bblr_pkg::K_R} * {8'd0, p1_r_reg}
                    + {8'd0, bblr_pkg::K_G} * {8'd0, p1_g_reg}
                    + {8'd0, bblr_pkg::K_B} * {8'd0, p1_b_reg}
                    + {8'd0, bblr_pkg::K_RND};
    assign addr_sum = {1'b0, p1_prod_reg} + {13'd0, p1_add_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_w_reg     <= 12'd640;
            eff_h_reg     <= 13'd480;
            cw_reg        <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            mask_reg      <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    bblr_pkg::CFG_WIDTH:  eff_w_reg <= w_clamp;
                    bblr_pkg::CFG_HEIGHT: eff_h_reg <= h_clamp;
                    bblr_pkg::CFG_ROTATE: cw_reg <= cfg_data[0];
                    default: ;
                endcase
                if (cfg_index == bblr_pkg::CFG_WIDTH || cfg_index == bblr_pkg::CFG_HEIGHT
                    || cfg_index == bblr_pkg::CFG_ROTATE)
                begin
                    col_reg <= '0;
                    row_reg <= '0;
                end
            end
            else if (in_acc)
            begin
                if ({1'b0, col_reg} == wm1)
                begin
                    col_reg <= '0;
                    row_reg <= ({1'b0, row_reg} == hm1) ? '0 : row_reg + 1'b1;
                end
                else
                    col_reg <= col_reg + 1'b1;
            end
            if (in_acc)
                s1_valid_reg <= 1'b1;
            else if (xfer)
                s1_valid_reg <= 1'b0;
            if (xfer)
                mask_reg <= new_mask;
            else if (adv)
                mask_reg <= mask_reg & ~pick_bit;
            if (adv)
            begin
                p1_valid_reg  <= mask_reg != '0;
                out_valid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rd_reg     <= mem[col_reg];
            s1_pix_reg <= raw_pixel;
            s1_c_reg   <= col_reg;
            s1_r_reg   <= row_reg;
        end
        if (xfer)
        begin
            mem[s1_c_reg] <= {s1_pix_reg, rd_reg[15:8]};
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i*3]   <= win_reg[i*3+1];
                win_reg[i*3+1] <= win_reg[i*3+2];
            end
            win_reg[2] <= rd_reg[7:0];
            win_reg[5] <= rd_reg[15:8];
            win_reg[8] <= s1_pix_reg;
            b_c_reg    <= s1_c_reg;
            b_r_reg    <= s1_r_reg;
        end
        if (adv)
        begin
            p1_r_reg    <= cr;
            p1_g_reg    <= cg;
            p1_b_reg    <= cb;
            p1_prod_reg <= {13'd0, mx} * {11'd0, eff_h_reg};
            p1_add_reg  <= addend;
            p1_last_reg <= (mask_reg & ~pick_bit) == '0;
            p1_done_reg <= ({1'b0, py} == hm1) && ({1'b0, px} == wm1);
            luma_reg    <= luma_sum[15:8];
            addr_reg    <= addr_sum[22:0];
            last_reg    <= p1_last_reg;
            done_reg    <= p1_done_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign luma        = luma_reg;
    assign out_address = addr_reg;
    assign last_of_run = last_reg;
    assign frame_done  = done_reg;

`ifndef SYNTHESIS
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(xfer && in_acc && s1_c_reg == col_reg))
        else $error("line store read and write hit the same column");
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> last_of_run)
        else $error("frame end not last of run");
    a_fill_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> s1_valid_reg)
        else $error("accepted item lost before line store stage");
`endif
endmodule
`default_nettype wire

[bench/bayer_bggr_to_luma_rotate_tb.sv]
// Testbench for the Bayer BGGR to luma rotate block: predictor and result scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module bayer_bggr_to_luma_rotate_tb;

    typedef struct packed {
        logic [7:0]  luma;
        logic [22:0] addr;
        logic        last;
        logic        done;
    } luma_result_t;

    class luma_scoreboard;
        logic [7:0] row_above [bblr_pkg::MAX_WIDTH];
        logic [7:0] row_above2 [bblr_pkg::MAX_WIDTH];
        logic [7:0] win [9];
        int unsigned col, row, width_reg, height_reg, cw;
        int unsigned ew, eh, wr, wc;
        luma_result_t pending [$];
        int errors;

        function void reset_state();
            foreach (win[i]) win[i] = 8'd0;
            col = 0; row = 0; width_reg = 640; height_reg = 480; cw = 0;
            pending.delete();
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [12:0] data);
            if (idx == bblr_pkg::CFG_WIDTH) width_reg = data[11:0];
            else if (idx == bblr_pkg::CFG_HEIGHT) height_reg = data;
            else if (idx == bblr_pkg::CFG_ROTATE) cw = data[0];
            else return;
            col = 0; row = 0;
        endfunction

        function bit fetch(int y, int x, output int unsigned v);
            int wy, wx;
            v = 0;
            if (y < 0 || x < 0 || y >= int'(eh) || x >= int'(ew)) return 0;
            wy = y - (int'(wr) - 2);
            wx = x - (int'(wc) - 2);
            if (wy < 0 || wy > 2 || wx < 0 || wx > 2) return 0;
            v = win[wy * 3 + wx];
            return 1;
        endfunction

        // mean over neighbours given as four (dy,dx) pairs; n of them used
        function int unsigned mean_of(int y, int x, int dys[4], int dxs[4], int n);
            int unsigned s, c, v;
            s = 0; c = 0;
            for (int i = 0; i < n; i++)
                if (fetch(y + dys[i], x + dxs[i], v)) begin
                    s += v; c++;
                end
            return c ? s / c : 0;
        endfunction

        function void predict_pixel(int unsigned y, int unsigned x);
            int unsigned own, r, g, b, a;
            int cy[4], cx[4], dy[4], dx[4], hy[4], hx[4], vy[4], vx[4];
            luma_result_t res;
            if (y >= eh || x >= ew) return;
            cy = '{-1, 1, 0, 0}; cx = '{0, 0, -1, 1};
            dy = '{-1, -1, 1, 1}; dx = '{-1, 1, -1, 1};
            hy = '{0, 0, 0, 0}; hx = '{-1, 1, 0, 0};
            vy = '{-1, 1, 0, 0}; vx = '{0, 0, 0, 0};
            void'(fetch(y, x, own));
            if (!y[0] && !x[0]) begin
                b = own; g = mean_of(y, x, cy, cx, 4); r = mean_of(y, x, dy, dx, 4);
            end
            else if (!y[0]) begin
                g = own; b = mean_of(y, x, hy, hx, 2); r = mean_of(y, x, vy, vx, 2);
            end
            else if (!x[0]) begin
                g = own; r = mean_of(y, x, hy, hx, 2); b = mean_of(y, x, vy, vx, 2);
            end
            else begin
                r = own; g = mean_of(y, x, cy, cx, 4); b = mean_of(y, x, dy, dx, 4);
            end
            a = cw ? x * eh + (eh - 1 - y) : (ew - 1 - x) * eh + y;
            res.luma = 8'((76 * r + 149 * g + 29 * b + 128) >> 8);
            res.addr = a[22:0];
            res.last = 1'b0;
            res.done = (y == eh - 1 && x == ew - 1);
            pending.push_back(res);
        endfunction

        function void note_pixel(logic [7:0] v);
            int unsigned r, c, above, above2, n_prior;
            ew = width_reg < 4 ? 4 :
                 (width_reg > bblr_pkg::MAX_WIDTH ? bblr_pkg::MAX_WIDTH : width_reg);
            eh = height_reg < 4 ? 4 :
                 (height_reg > bblr_pkg::MAX_HEIGHT ? bblr_pkg::MAX_HEIGHT : height_reg);
            if (col >= ew) col = 0;
            if (row >= eh) row = 0;
            r = row; c = col; wr = r; wc = c;
            above = row_above[c]; above2 = row_above2[c];
            row_above2[c] = row_above[c];
            row_above[c] = v;
            for (int i = 0; i < 3; i++) begin
                win[i * 3] = win[i * 3 + 1];
                win[i * 3 + 1] = win[i * 3 + 2];
            end
            win[2] = above2; win[5] = above; win[8] = v;
            n_prior = pending.size();
            if (r >= 1 && c >= 1) predict_pixel(r - 1, c - 1);
            if (r >= 1 && c == ew - 1) predict_pixel(r - 1, c);
            if (r == eh - 1 && c >= 1) predict_pixel(r, c - 1);
            if (r == eh - 1 && c == ew - 1) predict_pixel(r, c);
            if (pending.size() > n_prior) pending[$].last = 1'b1;
            c++;
            if (c >= ew) begin
                c = 0; r++;
                if (r >= eh) r = 0;
            end
            col = c; row = r;
        endfunction

        function void check_result(luma_result_t got);
            luma_result_t want;
            if (pending.size() == 0) begin
                $error("unexpected result luma=%0d addr=%0d", got.luma, got.addr);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.luma !== want.luma) begin
                $error("luma expected %0d actual %0d", want.luma, got.luma); errors++;
            end
            if (got.addr !== want.addr) begin
                $error("out_address expected %0d actual %0d", want.addr, got.addr); errors++;
            end
            if (got.last !== want.last) begin
                $error("last_of_run expected %0d actual %0d", want.last, got.last); errors++;
            end
            if (got.done !== want.done) begin
                $error("frame_done expected %0d actual %0d", want.done, got.done); errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = bblr_pkg::CFG_WIDTH;
    logic [12:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  raw_pixel = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  luma;
    logic [22:0] out_address;
    logic        last_of_run;
    logic        frame_done;

    luma_scoreboard sb;

    bayer_bggr_to_luma_rotate u_dut (.*);

    always #5 clk = ~clk;

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic write_reg(logic [1:0] idx, logic [12:0] data);
        @(posedge clk);
        cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_pixel(logic [7:0] v);
        int idle;
        idle = $urandom_range(0, 4);
        if (idle != 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1; raw_pixel <= v;
        do @(posedge clk); while (!in_ready);
        sb.note_pixel(v);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 100000) begin
            @(posedge clk); guard++;
        end
        repeat (10) @(posedge clk);
    endtask

    // random frame; mostly random bytes, some extremes
    task automatic run_frame(int w, int h, bit rot, int pixels);
        write_reg(bblr_pkg::CFG_WIDTH, 13'(w));
        write_reg(bblr_pkg::CFG_HEIGHT, 13'(h));
        write_reg(bblr_pkg::CFG_ROTATE, 13'(rot));
        for (int i = 0; i < pixels; i++)
            case ($urandom_range(0, 5))
                0: send_pixel(8'd0);
                1: send_pixel(8'd255);
                default: send_pixel(8'($urandom));
            endcase
        drain();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result('{luma, out_address, last_of_run, frame_done});
    end

    // result side: random wait before each result
    initial
    begin
        int wait_n;
        forever
        begin
            wait_n = $urandom_range(0, 4);
            if (wait_n != 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(rst_n && out_valid));
        end
    end

    initial
    begin
        sb = new();
        sb.reset_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes on a minimal frame, then random frames of clamped and unclamped sizes
        write_reg(bblr_pkg::CFG_WIDTH, 13'd4);
        write_reg(bblr_pkg::CFG_HEIGHT, 13'd4);
        write_reg(bblr_pkg::CFG_ROTATE, 13'd1);
        for (int i = 0; i < 16; i++)
            send_pixel(i[0] ? 8'd255 : (i[1] ? 8'd0 : 8'($urandom)));
        drain();
        run_frame(0, 13'h1FFF, 1'b0, 8);
        run_frame(5, 5, 1'b1, 25);
        run_frame(6, 4, 1'b0, 24);
        run_frame(4, 6, 1'b1, 12);
        run_frame(4095, 2, 1'b0, 8);
        run_frame(4, 4, 1'b0, 16);
        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
